>>> rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescape core: result
// kinds, the result record, the per-request result group and byte codes.
// ----------------------------------------------------------------------------
package jsu_pkg;

   // Most results that one request can cause: three UTF-8 bytes and a status
   localparam int unsigned MAX_RESULTS = 4;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_BYTE  = 3'd0,
      KIND_QUOTE = 3'd1,
      KIND_EOT   = 3'd2,
      KIND_LIMIT = 3'd3,
      KIND_HEX   = 3'd4,
      KIND_NOQ   = 3'd5
   } kind_type;

   // One result as seen on the response channel
   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    kind;
      logic [10:0] length;
      logic        last;
   } result_type;

   // All results of one request, slot 0 first
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [2:0]                   cnt;
   } group_type;

   // Byte codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U      = 8'h75;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CTRL_LF     = 8'h0A;
   localparam logic [7:0] CTRL_TAB    = 8'h09;
   localparam logic [7:0] CTRL_CR     = 8'h0D;
   localparam logic [7:0] CTRL_BS     = 8'h08;
   localparam logic [7:0] CTRL_FF     = 8'h0C;

   // UTF-8 encoding constants
   localparam logic [15:0] UTF8_LIM1  = 16'h0080;
   localparam logic [15:0] UTF8_LIM2  = 16'h0800;
   localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0]  UTF8_CONT  = 8'h80;

   localparam logic [10:0] MAX_LENGTH_RESET = 11'd512;

   // Hex digit decode: {valid, value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

>>> rtl/json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_core
// JSON string literal unescaper: one text byte per request, decoded string
// bytes and end/error status as responses.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------
//   req      | in        | in_byte, start_of_string
//   rsp      | out       | out_byte, kind, length, last
//   csr      | in        | max_length (write only, no handshake)
//
// A request is decoded in the cycle it is accepted; its first response is
// valid the next cycle. A request causes 0 to 4 responses, drained from the
// result register one per cycle while rsp_ready is high; requests with 0 or
// 1 responses go one per cycle unstalled; more hold the next until drained.
// Synchronous active-high reset clears the scanner state and sets
// max_length to 512. req_ready is high while the result register is empty
// or its one remaining response leaves in the same cycle; a stalled
// response holds it low.
// ----------------------------------------------------------------------------
module json_string_unescape_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_start_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [2:0]  rsp_kind,
   output logic [10:0] rsp_length,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [10:0] csr_wr_data
);

   jsu_pkg::group_type  group;
   jsu_pkg::result_type rsp_result;
   logic                accept;

   assign accept = req_valid && req_ready;

   // Decode stage
   jsu_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .in_byte         (req_in_byte),
      .start_of_string (req_start_of_string),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .group           (group)
   );

   // Result register
   jsu_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .group      (group),
      .can_load   (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_out_byte = rsp_result.out_byte;
   assign rsp_kind     = 3'(rsp_result.kind);
   assign rsp_length   = rsp_result.length;
   assign rsp_last     = rsp_result.last;

endmodule

>>> rtl/jsu_decode.sv
// ----------------------------------------------------------------------------
// jsu_decode
// Scanner state and byte decode. Holds mode, escape progress, code point,
// decoded count and the length limit; forms the result group of each
// accepted request in one pass.
// ----------------------------------------------------------------------------
module jsu_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic                start_of_string,
   input  logic                csr_wr_en,
   input  logic [10:0]         csr_wr_data,
   output jsu_pkg::group_type  group
);

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_STR  = 2'd1,
      MODE_ESC  = 2'd2,
      MODE_HEX  = 2'd3
   } mode_type;

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_seen_ff, hex_seen_in;
   logic [15:0] code_point_ff, code_point_in;
   logic [10:0] byte_count_ff, byte_count_in;
   logic [10:0] max_length_ff;

   logic        put_char;
   logic [7:0]  cbytes [4];
   logic [2:0]  ccnt;
   logic        eot_tail;
   logic [4:0]  hexd;
   logic [15:0] cp;
   logic [11:0] c_sum;
   logic        limit_hit;
   logic        tail;
   logic [2:0]  n_res;
   jsu_pkg::result_type single;
   logic        single_valid;

   // Byte decode and next state
   always_comb begin
      mode_in       = mode_ff;
      hex_seen_in   = hex_seen_ff;
      code_point_in = code_point_ff;
      byte_count_in = byte_count_ff;
      put_char      = 1'b0;
      eot_tail      = 1'b0;
      ccnt          = 3'd1;
      cbytes[0]     = in_byte;
      cbytes[1]     = 8'd0;
      cbytes[2]     = 8'd0;
      cbytes[3]     = 8'd0;
      single        = '0;
      single_valid  = 1'b0;
      hexd          = jsu_pkg::hex_value(in_byte);
      cp            = {code_point_ff[11:0], hexd[3:0]};

      if (start_of_string) begin
         hex_seen_in   = 2'd0;
         code_point_in = 16'd0;
         byte_count_in = 11'd0;
         if (in_byte == jsu_pkg::CHAR_QUOTE) begin
            mode_in = MODE_STR;
         end else begin
            mode_in      = MODE_IDLE;
            single_valid = 1'b1;
            single.kind  = jsu_pkg::KIND_NOQ;
         end
      end else begin
         case (mode_ff)
            MODE_STR: begin
               if (in_byte == jsu_pkg::CHAR_NUL) begin
                  single_valid  = 1'b1;
                  single.kind   = jsu_pkg::KIND_EOT;
                  single.length = byte_count_ff;
                  mode_in       = MODE_IDLE;
               end else if (in_byte == jsu_pkg::CHAR_QUOTE) begin
                  single_valid  = 1'b1;
                  single.kind   = jsu_pkg::KIND_QUOTE;
                  single.length = byte_count_ff;
                  mode_in       = MODE_IDLE;
               end else if (in_byte == jsu_pkg::CHAR_BSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  put_char = 1'b1;
               end
            end
            MODE_ESC: begin
               if (in_byte == jsu_pkg::CHAR_NUL) begin
                  // dangling backslash is kept, then end of text or the limit status
                  put_char  = 1'b1;
                  eot_tail  = 1'b1;
                  cbytes[0] = jsu_pkg::CHAR_BSLASH;
               end else if (in_byte == jsu_pkg::CHAR_U) begin
                  mode_in       = MODE_HEX;
                  hex_seen_in   = 2'd0;
                  code_point_in = 16'd0;
               end else begin
                  put_char = 1'b1;
                  case (in_byte)
                     jsu_pkg::CHAR_N: cbytes[0] = jsu_pkg::CTRL_LF;
                     jsu_pkg::CHAR_T: cbytes[0] = jsu_pkg::CTRL_TAB;
                     jsu_pkg::CHAR_R: cbytes[0] = jsu_pkg::CTRL_CR;
                     jsu_pkg::CHAR_B: cbytes[0] = jsu_pkg::CTRL_BS;
                     jsu_pkg::CHAR_F: cbytes[0] = jsu_pkg::CTRL_FF;
                     default:         cbytes[0] = in_byte;
                  endcase
               end
            end
            MODE_HEX: begin
               if (!hexd[4]) begin
                  single_valid  = 1'b1;
                  single.kind   = jsu_pkg::KIND_HEX;
                  single.length = byte_count_ff;
                  mode_in       = MODE_IDLE;
                  hex_seen_in   = 2'd0;
                  code_point_in = 16'd0;
               end else if (hex_seen_ff != 2'd3) begin
                  code_point_in = cp;
                  hex_seen_in   = hex_seen_ff + 2'd1;
               end else begin
                  // fourth digit: encode code point as UTF-8
                  hex_seen_in   = 2'd0;
                  code_point_in = 16'd0;
                  put_char      = 1'b1;
                  if (cp < jsu_pkg::UTF8_LIM1) begin
                     cbytes[0] = cp[7:0];
                  end else if (cp < jsu_pkg::UTF8_LIM2) begin
                     ccnt      = 3'd2;
                     cbytes[0] = jsu_pkg::UTF8_LEAD2 | {3'd0, cp[10:6]};
                     cbytes[1] = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
                  end else begin
                     ccnt      = 3'd3;
                     cbytes[0] = jsu_pkg::UTF8_LEAD3 | {4'd0, cp[15:12]};
                     cbytes[1] = jsu_pkg::UTF8_CONT | {2'd0, cp[11:6]};
                     cbytes[2] = jsu_pkg::UTF8_CONT | {2'd0, cp[5:0]};
                  end
               end
            end
            default: begin
               // outside a string: byte ignored
            end
         endcase
      end

      // Length update and limit check after a whole character
      c_sum     = {1'b0, byte_count_ff} + {9'd0, ccnt};
      limit_hit = ({1'b0, c_sum} + 13'd1) >= {2'b00, max_length_ff};
      tail      = 1'b0;
      if (put_char) begin
         byte_count_in = c_sum[10:0];
         mode_in       = (limit_hit || eot_tail) ? MODE_IDLE : MODE_STR;
         tail          = limit_hit || eot_tail;
      end
   end

   // Result group assembly
   always_comb begin
      group = '0;
      if (put_char) begin
         n_res = ccnt + {2'd0, tail};
         for (int k = 0; k < jsu_pkg::MAX_RESULTS; k++) begin
            if (3'(k) < ccnt) begin
               group.res[k].out_byte = cbytes[k];
               group.res[k].kind     = jsu_pkg::KIND_BYTE;
               group.res[k].length   = byte_count_ff + 11'(k + 1);
            end else if (3'(k) == ccnt && tail) begin
               group.res[k].kind   = limit_hit ? jsu_pkg::KIND_LIMIT : jsu_pkg::KIND_EOT;
               group.res[k].length = c_sum[10:0];
            end
            group.res[k].last = (3'(k) == n_res - 3'd1);
         end
      end else begin
         n_res        = {2'd0, single_valid};
         group.res[0] = single;
         group.res[0].last = single_valid;
      end
      group.cnt = accept ? n_res : 3'd0;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         hex_seen_ff   <= 2'd0;
         code_point_ff <= 16'd0;
         byte_count_ff <= 11'd0;
         max_length_ff <= jsu_pkg::MAX_LENGTH_RESET;
      end else begin
         if (accept) begin
            mode_ff       <= mode_in;
            hex_seen_ff   <= hex_seen_in;
            code_point_ff <= code_point_in;
            byte_count_ff <= byte_count_in;
         end
         if (csr_wr_en) begin
            max_length_ff <= csr_wr_data;
         end
      end
   end

endmodule

>>> rtl/jsu_drain.sv
// ----------------------------------------------------------------------------
// jsu_drain
// Result register. Loads the result group of one request and presents it
// one result per cycle unless stalled; frees for the next group on last pop.
// ----------------------------------------------------------------------------
module jsu_drain (
   input  logic                clock,
   input  logic                reset,
   input  jsu_pkg::group_type  group,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output jsu_pkg::result_type rsp_result
);

   jsu_pkg::result_type [jsu_pkg::MAX_RESULTS-1:0] res_ff, res_in;
   logic [2:0] rem_ff, rem_in;
   logic       pop;

   assign rsp_valid  = (rem_ff != 3'd0);
   assign rsp_result = res_ff[0];
   assign pop        = rsp_valid && rsp_ready;
   // Free when empty or when the last held result leaves this cycle
   assign can_load   = (rem_ff == 3'd0) || ((rem_ff == 3'd1) && rsp_ready);

   // Next contents: new group wins over a shift
   always_comb begin
      res_in = res_ff;
      rem_in = rem_ff;
      if (pop) begin
         for (int k = 0; k < jsu_pkg::MAX_RESULTS - 1; k++) begin
            res_in[k] = res_ff[k+1];
         end
         rem_in = rem_ff - 3'd1;
      end
      if (group.cnt != 3'd0) begin
         res_in = group.res;
         rem_in = group.cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
      end else begin
         rem_ff <= rem_in;
      end
      res_ff <= res_in;
   end

endmodule

>>> tb/tb_json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// tb_json_string_unescape_core
// Self-checking bench for the JSON string unescape core. A short stimulus
// table covers start-flag handling, plain bytes, escapes, a \u escape and
// the error cases. It is followed by randomized phases of mostly well-formed
// string literals with random content, mixed with broken escapes and noise.
// These phases run under several max_length settings and under varied
// request and response pacing. An in-bench scanner model predicts the
// untyped responses. Responses are compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_HALF     = 5;
   localparam int          CYCLE_LIMIT  = 300000;
   localparam int          SETTLE       = 6;
   localparam int          PHASE_ITEMS  = 45;
   localparam int          NUM_PHASES   = 6;
   localparam int          NUM_ROWS     = 25;
   localparam logic [7:0]  CHAR_SLASH   = 8'h2F;

   // Scanner modes of the bench model
   typedef enum logic [1:0] {
      SCAN_IDLE,
      SCAN_STRING,
      SCAN_ESCAPE,
      SCAN_HEX
   } scan_mode_type;

   // One directed row; the typed result applies only where typed is set
   typedef struct {
      logic [7:0]        text;
      logic              sos;
      logic              typed;
      logic [7:0]        out_byte;
      jsu_pkg::kind_type kind;
      logic [10:0]       length;
   } stim_row_type;

   // Per-request note: a typed expectation replaces the model's results
   typedef struct {
      logic                typed;
      jsu_pkg::result_type res;
   } request_note_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        req_start_of_string;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic [2:0]  rsp_kind;
   logic [10:0] rsp_length;
   logic        rsp_last;
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;

   // Scanner model state
   scan_mode_type       pm_mode       = SCAN_IDLE;
   int unsigned         pm_hex_cnt    = 0;
   logic [15:0]         pm_code       = '0;
   logic [10:0]         pm_count      = '0;
   logic [10:0]         pm_max_length = jsu_pkg::MAX_LENGTH_RESET;
   jsu_pkg::result_type step_res [jsu_pkg::MAX_RESULTS];
   int                  step_cnt;

   jsu_pkg::result_type decoded_q [$];
   request_note_type    request_note_q [$];
   int unsigned   req_accept_cnt = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count    = 0;
   int unsigned   req_idle_pct   = 0;
   int unsigned   rsp_stall_pct  = 0;
   int unsigned   phase_items;

   logic [7:0] escape_letters [8] = '{jsu_pkg::CHAR_N, jsu_pkg::CHAR_T,
                                      jsu_pkg::CHAR_R, jsu_pkg::CHAR_B,
                                      jsu_pkg::CHAR_F, jsu_pkg::CHAR_QUOTE,
                                      jsu_pkg::CHAR_BSLASH, CHAR_SLASH};

   // Directed requests
   stim_row_type directed_rows [NUM_ROWS] = '{
      // byte outside a string is ignored
      '{8'h41,                1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      // start flag without a quote
      '{8'h78,                1'b1, 1'b1, 8'h00, jsu_pkg::KIND_NOQ,   11'd0},
      '{jsu_pkg::CHAR_QUOTE,  1'b1, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{8'hFF,                1'b0, 1'b1, 8'hFF, jsu_pkg::KIND_BYTE,  11'd1},
      '{jsu_pkg::CHAR_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{jsu_pkg::CHAR_N,      1'b0, 1'b1, jsu_pkg::CTRL_LF,
        jsu_pkg::KIND_BYTE,  11'd2},
      '{jsu_pkg::CHAR_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      // unknown escape passes the byte through
      '{8'h71,                1'b0, 1'b1, 8'h71, jsu_pkg::KIND_BYTE,  11'd3},
      // \uFFFF: three UTF-8 bytes
      '{jsu_pkg::CHAR_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{jsu_pkg::CHAR_U,      1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{8'h46,                1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{8'h66,                1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{8'h46,                1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{8'h66,                1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      // bad hex digit
      '{jsu_pkg::CHAR_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{jsu_pkg::CHAR_U,      1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{8'h67,                1'b0, 1'b1, 8'h00, jsu_pkg::KIND_HEX,   11'd6},
      '{jsu_pkg::CHAR_QUOTE,  1'b1, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{8'h01,                1'b0, 1'b1, 8'h01, jsu_pkg::KIND_BYTE,  11'd1},
      // start flag inside a string drops it silently
      '{jsu_pkg::CHAR_QUOTE,  1'b1, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      // backslash then end of text
      '{jsu_pkg::CHAR_BSLASH, 1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{jsu_pkg::CHAR_NUL,    1'b0, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{jsu_pkg::CHAR_QUOTE,  1'b1, 1'b0, 8'h00, jsu_pkg::KIND_BYTE,  11'd0},
      '{jsu_pkg::CHAR_QUOTE,  1'b0, 1'b1, 8'h00, jsu_pkg::KIND_QUOTE, 11'd0},
      '{8'h80,                1'b1, 1'b1, 8'h00, jsu_pkg::KIND_NOQ,   11'd0}
   };

   json_string_unescape_core uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .req_start_of_string (req_start_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_kind            (rsp_kind),
      .rsp_length          (rsp_length),
      .rsp_last            (rsp_last),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // Scanner model
   // ---------------------------------------------------------------------

   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   task automatic add_result(input logic [7:0] b, input jsu_pkg::kind_type k,
                             input logic [10:0] len);
      step_res[step_cnt] = '{out_byte: (k == jsu_pkg::KIND_BYTE) ? b : 8'h00,
                             kind: k, length: len, last: 1'b0};
      step_cnt++;
   endtask

   // Emit the bytes of one decoded character, then apply the length limit
   task automatic put_char(input logic [7:0] utf [3], input int n);
      int unsigned c;
      c = pm_count;
      for (int i = 0; i < n; i++) begin
         c++;
         add_result(utf[i], jsu_pkg::KIND_BYTE, 11'(c));
      end
      pm_count = 11'(c);
      pm_mode  = SCAN_STRING;
      if (c + 1 >= pm_max_length) begin
         add_result(8'h00, jsu_pkg::KIND_LIMIT, 11'(c));
         pm_mode = SCAN_IDLE;
      end
   endtask

   // Advance the model by one text byte; results land in step_res
   task automatic decode_text_byte(input logic [7:0] b, input logic sos);
      int          digit;
      logic [15:0] cp;
      logic [7:0]  utf [3];
      step_cnt = 0;
      utf = '{8'h00, 8'h00, 8'h00};
      if (sos) begin
         pm_hex_cnt = 0;
         pm_code    = '0;
         pm_count   = '0;
         if (b == jsu_pkg::CHAR_QUOTE) begin
            pm_mode = SCAN_STRING;
         end else begin
            pm_mode = SCAN_IDLE;
            add_result(8'h00, jsu_pkg::KIND_NOQ, 11'd0);
         end
      end else begin
         case (pm_mode)
            SCAN_STRING: begin
               if (b == jsu_pkg::CHAR_NUL) begin
                  add_result(8'h00, jsu_pkg::KIND_EOT, pm_count);
                  pm_mode = SCAN_IDLE;
               end else if (b == jsu_pkg::CHAR_QUOTE) begin
                  add_result(8'h00, jsu_pkg::KIND_QUOTE, pm_count);
                  pm_mode = SCAN_IDLE;
               end else if (b == jsu_pkg::CHAR_BSLASH) begin
                  pm_mode = SCAN_ESCAPE;
               end else begin
                  utf[0] = b;
                  put_char(utf, 1);
               end
            end
            SCAN_ESCAPE: begin
               if (b == jsu_pkg::CHAR_NUL) begin
                  // dangling backslash is kept, then end of text or the limit status
                  utf[0] = jsu_pkg::CHAR_BSLASH;
                  put_char(utf, 1);
                  if (pm_mode != SCAN_IDLE) begin
                     add_result(8'h00, jsu_pkg::KIND_EOT, pm_count);
                     pm_mode = SCAN_IDLE;
                  end
               end else if (b == jsu_pkg::CHAR_U) begin
                  pm_mode    = SCAN_HEX;
                  pm_hex_cnt = 0;
                  pm_code    = '0;
               end else begin
                  case (b)
                     jsu_pkg::CHAR_N: utf[0] = jsu_pkg::CTRL_LF;
                     jsu_pkg::CHAR_T: utf[0] = jsu_pkg::CTRL_TAB;
                     jsu_pkg::CHAR_R: utf[0] = jsu_pkg::CTRL_CR;
                     jsu_pkg::CHAR_B: utf[0] = jsu_pkg::CTRL_BS;
                     jsu_pkg::CHAR_F: utf[0] = jsu_pkg::CTRL_FF;
                     default:         utf[0] = b;
                  endcase
                  put_char(utf, 1);
               end
            end
            SCAN_HEX: begin
               digit = hex_digit_value(b);
               if (digit < 0) begin
                  add_result(8'h00, jsu_pkg::KIND_HEX, pm_count);
                  pm_mode    = SCAN_IDLE;
                  pm_hex_cnt = 0;
                  pm_code    = '0;
               end else begin
                  cp = {pm_code[11:0], 4'(digit)};
                  if (pm_hex_cnt < 3) begin
                     pm_code = cp;
                     pm_hex_cnt++;
                  end else begin
                     pm_hex_cnt = 0;
                     pm_code    = '0;
                     // UTF-8 encoding, one to three bytes
                     if (cp < jsu_pkg::UTF8_LIM1) begin
                        utf[0] = cp[7:0];
                        put_char(utf, 1);
                     end else if (cp < jsu_pkg::UTF8_LIM2) begin
                        utf[0] = jsu_pkg::UTF8_LEAD2 | 8'(cp[10:6]);
                        utf[1] = jsu_pkg::UTF8_CONT | 8'(cp[5:0]);
                        put_char(utf, 2);
                     end else begin
                        utf[0] = jsu_pkg::UTF8_LEAD3 | 8'(cp[15:12]);
                        utf[1] = jsu_pkg::UTF8_CONT | 8'(cp[11:6]);
                        utf[2] = jsu_pkg::UTF8_CONT | 8'(cp[5:0]);
                        put_char(utf, 3);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (step_cnt > 0) step_res[step_cnt-1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Scoreboard: runs on every rising edge after reset
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : scoreboard
      request_note_type    note;
      jsu_pkg::result_type got;
      jsu_pkg::result_type want;
      if (!reset) begin
         // response check against the oldest expectation
         if (rsp_valid && rsp_ready) begin
            got = '{out_byte: rsp_out_byte, kind: jsu_pkg::kind_type'(rsp_kind),
                    length: rsp_length, last: rsp_last};
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("unexpected response byte %h kind %0d len %0d",
                                         got.out_byte, got.kind, got.length));
            end else begin
               want = decoded_q.pop_front();
               if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                   got.length !== want.length || got.last !== want.last) begin
                  report_mismatch($sformatf(
                     "got byte %h kind %0d len %0d last %b, exp byte %h kind %0d len %0d last %b",
                     got.out_byte, got.kind, got.length, got.last,
                     want.out_byte, want.kind, want.length, want.last));
               end
            end
         end
         // accepted request: predict its responses
         if (req_valid && req_ready) begin
            req_accept_cnt++;
            note = request_note_q.pop_front();
            decode_text_byte(req_in_byte, req_start_of_string);
            if (note.typed) begin
               decoded_q.push_back(note.res);
            end else begin
               for (int i = 0; i < step_cnt; i++) decoded_q.push_back(step_res[i]);
            end
         end
      end
   end

   // Response stalls, redrawn every cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [7:0] b, input logic sos,
                               input logic typed, input jsu_pkg::result_type tres);
      int unsigned seen;
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      request_note_q.push_back('{typed: typed, res: tres});
      seen = req_accept_cnt;
      req_valid           <= 1'b1;
      req_in_byte         <= b;
      req_start_of_string <= sos;
      do @(negedge clock); while (req_accept_cnt == seen);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic sos);
      send_request(b, sos, 1'b0, '0);
      phase_items++;
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255));
      while (b == jsu_pkg::CHAR_QUOTE || b == jsu_pkg::CHAR_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < 10) return 8'("0" + nib);
      return 8'(($urandom_range(1) ? "A" : "a") + nib - 10);
   endfunction

   function automatic logic [7:0] bad_hex_char();
      logic [7:0] b;
      if ($urandom_range(2) == 0) return jsu_pkg::CHAR_NUL;
      do b = 8'($urandom_range(255));
      while (hex_digit_value(b) >= 0);
      return b;
   endfunction

   task automatic send_unicode(input logic [15:0] cp);
      send_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
      send_byte(jsu_pkg::CHAR_U, 1'b0);
      for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4]), 1'b0);
   endtask

   // One string literal with random content and a random ending
   task automatic send_string();
      int unsigned units;
      int unsigned digits;
      logic [7:0]  b;
      logic [15:0] cp;
      units = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(8);
      send_byte(jsu_pkg::CHAR_QUOTE, 1'b1);
      repeat (units) begin
         case ($urandom_range(9))
            0, 1, 2, 3: send_byte(plain_char(), 1'b0);
            4, 5, 6: begin
               send_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
               if ($urandom_range(8) == 0) begin
                  do b = 8'($urandom_range(1, 255)); while (b == jsu_pkg::CHAR_U);
               end else begin
                  b = escape_letters[$urandom_range(7)];
               end
               send_byte(b, 1'b0);
            end
            default: begin
               case ($urandom_range(2))
                  0:       cp = 16'($urandom_range(16'h007F));
                  1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
                  default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
               endcase
               send_unicode(cp);
            end
         endcase
      end
      case ($urandom_range(9))
         6: send_byte(jsu_pkg::CHAR_NUL, 1'b0);
         7: begin
            send_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
            send_byte(jsu_pkg::CHAR_NUL, 1'b0);
         end
         8: begin
            // broken \u escape
            send_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
            send_byte(jsu_pkg::CHAR_U, 1'b0);
            digits = $urandom_range(3);
            repeat (digits) send_byte(hex_char(4'($urandom_range(15))), 1'b0);
            send_byte(bad_hex_char(), 1'b0);
         end
         9: ;  // left open, the next start flag drops it
         default: send_byte(jsu_pkg::CHAR_QUOTE, 1'b0);
      endcase
   endtask

   // Random bytes with an occasional start flag
   task automatic send_noise();
      repeat ($urandom_range(1, 4))
         send_byte(8'($urandom_range(255)), $urandom_range(4) == 0);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (decoded_q.size() != 0 || request_note_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_max_length(input logic [10:0] v);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= v;
      pm_max_length  = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      logic [10:0]  phase_cfg [NUM_PHASES];
      stim_row_type row;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_in_byte         = 8'h00;
      req_start_of_string = 1'b0;
      rsp_ready           = 1'b0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      phase_items         = 0;
      phase_cfg = '{11'd1024, 11'd2, 11'd3, 11'd7,
                    11'($urandom_range(2, 1024)), jsu_pkg::MAX_LENGTH_RESET};

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table at the reset max_length
      for (int r = 0; r < NUM_ROWS; r++) begin
         row = directed_rows[r];
         send_request(row.text, row.sos, row.typed,
                      '{out_byte: row.out_byte, kind: row.kind,
                        length: row.length, last: 1'b1});
      end
      wait_drained();

      // random phases, each with its own limit and pacing
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_max_length(phase_cfg[p]);
         case (p % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 84; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 84; end
            default: begin req_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_string();
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/jsu_pkg.sv
rtl/jsu_decode.sv
rtl/jsu_drain.sv
rtl/json_string_unescape_core.sv
tb/tb_json_string_unescape_core.sv
